// ===== src/pgc_pkg.sv =====
// Package with the shared types and constants of the polygon geofence clamp.
`timescale 1ns / 1ps

package pgc_pkg;

	localparam int IDX_WIDTH = 6;
	localparam int CNT_WIDTH = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_PREV   = 13'b0000000000010,
		ST_FETCH  = 13'b0000000000100,
		ST_LOAD   = 13'b0000000001000,
		ST_MULT   = 13'b0000000010000,
		ST_DECIDE = 13'b0000000100000,
		ST_DIV    = 13'b0000001000000,
		ST_ROUND  = 13'b0000010000000,
		ST_APPLY  = 13'b0000100000000,
		ST_DIST   = 13'b0001000000000,
		ST_CMP    = 13'b0010000000000,
		ST_SQRT   = 13'b0100000000000,
		ST_FIN    = 13'b1000000000000
	} state_t;

endpackage

// ===== src/pgc_if.sv =====
// Handshake interfaces for the vertex and query items and for the result items.
`timescale 1ns / 1ps

interface pgc_req_if #(parameter int COORD_WIDTH = 32);
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic        [pgc_pkg::IDX_WIDTH-1:0] vertex_index;
	logic signed [COORD_WIDTH-1:0]        coord_x;
	logic signed [COORD_WIDTH-1:0]        coord_z;

	modport source (output valid, output operation, output vertex_index,
		output coord_x, output coord_z, input ready);
	modport sink (input valid, input operation, input vertex_index,
		input coord_x, input coord_z, output ready);
endinterface

interface pgc_rsp_if #(parameter int COORD_WIDTH = 32);
	logic                        valid;
	logic                        ready;
	logic                        inside_res;
	logic signed [COORD_WIDTH-1:0] goal_x;
	logic signed [COORD_WIDTH-1:0] goal_z;
	logic        [COORD_WIDTH:0]   distance;

	modport source (output valid, output inside_res, output goal_x, output goal_z,
		output distance, input ready);
	modport sink (input valid, input inside_res, input goal_x, input goal_z,
		input distance, output ready);
endinterface

// ===== src/polygon_geofence_clamp_top.sv =====
// Polygon geofence clamp: vertex store, edge sequencer, divider and square root.
// A query item runs the shared multiplier steps for each edge and the bit-serial
// divider for each edge of nonzero length whose projection falls on it, then the
// bit-serial square root, which a point inside skips; one vertex is taken from
// the memory per edge.
// Reset clears the control state and the vertex count; the stores stay undefined.
`timescale 1ns / 1ps

module polygon_geofence_clamp_top #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pgc_pkg::CNT_WIDTH-1:0]  cfg_data,
	pgc_req_if.sink                        req,
	pgc_rsp_if.source                      rsp
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * W + 2;
	localparam int SW = 2 * W + 3;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NC = $clog2(MAX_VERTICES + 1);
	localparam int NW = (NC > pgc_pkg::CNT_WIDTH) ? NC : pgc_pkg::CNT_WIDTH;
	localparam int BW = $clog2(W + 1);

	function automatic logic signed [DW-1:0] dif(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		dif = {a[W-1], a} - {b[W-1], b};
	endfunction

	function automatic logic [PW+1:0] div_step(input logic [PW-1:0] r, input logic add,
		input logic [SW-1:0] nu, input logic [SW-1:0] de);
		logic [SW-1:0] t;
		logic [SW-1:0] dd;
		t = {r, 1'b0} + (add ? nu : '0);
		dd = {de[SW-2:0], 1'b0};
		if (t >= dd) begin
			div_step = {2'd2, PW'(t - dd)};
		end else if (t >= de) begin
			div_step = {2'd1, PW'(t - de)};
		end else begin
			div_step = {2'd0, PW'(t)};
		end
	endfunction

	pgc_pkg::state_t state_q;

	logic [pgc_pkg::CNT_WIDTH-1:0] count_q;
	logic [NW-1:0]                 n_w;
	logic [NW-1:0]                 n_m1;
	logic [NW-1:0]                 idx_ext;
	logic [AW-1:0]                 last;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;

	logic signed [W-1:0] mem_x [MAX_VERTICES];
	logic signed [W-1:0] mem_z [MAX_VERTICES];
	logic signed [W-1:0] rd_x_q, rd_z_q;

	logic [AW-1:0]       i_q;
	logic [2:0]          step_q;
	logic [BW-1:0]       bit_q;
	logic signed [W-1:0] px_q, pz_q, ax_q, az_q, bx_q, bz_q, cx_q, cz_q;

	logic signed [DW-1:0] dx, dz, dd_z, ma, mb;
	logic [2:0]           mul_sel;
	logic signed [PW-1:0] mul_q, p1_q;
	logic signed [SW-1:0] mul_ext, num_q, den_q;
	logic                 odd_q, have_q, cross_cond, cross_hit;

	logic [SW-1:0] d2_q, best_q, chosen;
	logic          better;

	logic [PW-1:0] rx_q, rz_q;
	logic [DW-1:0] qx_q, qz_q, mx_q, mz_q;
	logic          sx_q, sz_q;
	logic [PW+1:0] stx, stz;
	logic [W+1:0]  sqx, sqz, cx_sum, cz_sum;

	logic [PW-1:0] s_q;
	logic [W+2:0]  rem_q, rem_n, trial;
	logic [W:0]    root_q, root_n;
	logic [W+2:0]  rem_next;

	logic                res_in_q;
	logic signed [W-1:0] res_x_q, res_z_q;
	logic [W:0]          res_d_q;

	logic                out_v_q, out_in_q;
	logic signed [W-1:0] out_x_q, out_z_q;
	logic [W:0]          out_d_q;
	logic                out_load;

	assign n_w     = (NW'(count_q) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_q);
	assign n_m1    = n_w - NW'(1);
	assign last    = n_m1[AW-1:0];
	assign idx_ext = NW'(req.vertex_index);
	assign rd_addr = (state_q == pgc_pkg::ST_IDLE) ? last : i_q;
	assign wr_en   = (state_q == pgc_pkg::ST_IDLE) && req.valid
		&& (req.operation == pgc_pkg::OP_WRITE) && (idx_ext < NW'(MAX_VERTICES));

	assign req.ready = (state_q == pgc_pkg::ST_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[idx_ext[AW-1:0]] <= req.coord_x;
			mem_z[idx_ext[AW-1:0]] <= req.coord_z;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_z_q <= mem_z[rd_addr];
	end

	assign dx   = dif(bx_q, ax_q);
	assign dz   = dif(bz_q, az_q);
	assign dd_z = dif(az_q, bz_q);

	assign mul_sel = (state_q == pgc_pkg::ST_DIST) ? {2'b11, step_q[0]} : step_q;

	always_comb begin
		case (mul_sel)
			3'd0: begin ma = dif(pz_q, bz_q); mb = dif(ax_q, bx_q); end
			3'd1: begin ma = dif(px_q, bx_q); mb = dif(az_q, bz_q); end
			3'd2: begin ma = dx; mb = dx; end
			3'd3: begin ma = dz; mb = dz; end
			3'd4: begin ma = dif(px_q, ax_q); mb = dx; end
			3'd5: begin ma = dif(pz_q, az_q); mb = dz; end
			3'd6: begin ma = dif(px_q, cx_q); mb = dif(px_q, cx_q); end
			default: begin ma = dif(pz_q, cz_q); mb = dif(pz_q, cz_q); end
		endcase
	end

	assign mul_ext = {mul_q[PW-1], mul_q};

	assign cross_cond = ((bz_q < pz_q) && (az_q >= pz_q)) || ((az_q < pz_q) && (bz_q >= pz_q));
	assign cross_hit  = cross_cond && (((!dd_z[DW-1]) && (dd_z != '0) && (p1_q < mul_q))
		|| (dd_z[DW-1] && (p1_q > mul_q)));

	assign stx = div_step(rx_q, mx_q[bit_q], num_q, den_q);
	assign stz = div_step(rz_q, mz_q[bit_q], num_q, den_q);

	assign sqx    = sx_q ? -{1'b0, qx_q} : {1'b0, qx_q};
	assign sqz    = sz_q ? -{1'b0, qz_q} : {1'b0, qz_q};
	assign cx_sum = {ax_q[W-1], ax_q[W-1], ax_q} + sqx;
	assign cz_sum = {az_q[W-1], az_q[W-1], az_q} + sqz;

	assign better = !have_q || (d2_q < best_q);
	assign chosen = better ? d2_q : best_q;

	assign rem_n    = {rem_q[W:0], s_q[PW-1:PW-2]};
	assign trial    = {root_q, 2'b01};
	assign rem_next = (rem_n >= trial) ? (rem_n - trial) : rem_n;
	assign root_n   = (rem_n >= trial) ? {root_q[W-1:0], 1'b1} : {root_q[W-1:0], 1'b0};

	assign out_load = (state_q == pgc_pkg::ST_FIN) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk) begin
		mul_q <= PW'(ma) * PW'(mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgc_pkg::ST_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			step_q  <= '0;
			bit_q   <= '0;
			i_q     <= '0;
			odd_q   <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				pgc_pkg::ST_IDLE: begin
					if (req.valid && (req.operation == pgc_pkg::OP_QUERY)) begin
						odd_q  <= 1'b0;
						have_q <= 1'b0;
						i_q    <= '0;
						state_q <= (n_w == '0) ? pgc_pkg::ST_FIN : pgc_pkg::ST_PREV;
					end
				end
				pgc_pkg::ST_PREV:  state_q <= pgc_pkg::ST_FETCH;
				pgc_pkg::ST_FETCH: state_q <= pgc_pkg::ST_LOAD;
				pgc_pkg::ST_LOAD: begin
					step_q  <= '0;
					state_q <= pgc_pkg::ST_MULT;
				end
				pgc_pkg::ST_MULT: begin
					step_q <= step_q + 3'd1;
					if ((step_q == 3'd2) && cross_hit) begin
						odd_q <= ~odd_q;
					end
					if (step_q == 3'd6) begin
						state_q <= pgc_pkg::ST_DECIDE;
					end
				end
				pgc_pkg::ST_DECIDE: begin
					step_q <= '0;
					bit_q  <= BW'(W);
					if ((den_q == '0) || num_q[SW-1] || (num_q > den_q)) begin
						state_q <= pgc_pkg::ST_DIST;
					end else begin
						state_q <= pgc_pkg::ST_DIV;
					end
				end
				pgc_pkg::ST_DIV: begin
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						state_q <= pgc_pkg::ST_ROUND;
					end
				end
				pgc_pkg::ST_ROUND: state_q <= pgc_pkg::ST_APPLY;
				pgc_pkg::ST_APPLY: begin
					step_q  <= '0;
					state_q <= pgc_pkg::ST_DIST;
				end
				pgc_pkg::ST_DIST: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						state_q <= pgc_pkg::ST_CMP;
					end
				end
				pgc_pkg::ST_CMP: begin
					have_q <= 1'b1;
					if (i_q == last) begin
						bit_q   <= BW'(W);
						state_q <= odd_q ? pgc_pkg::ST_FIN : pgc_pkg::ST_SQRT;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= pgc_pkg::ST_FETCH;
					end
				end
				pgc_pkg::ST_SQRT: begin
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						state_q <= pgc_pkg::ST_FIN;
					end
				end
				pgc_pkg::ST_FIN: begin
					if (out_load) begin
						state_q <= pgc_pkg::ST_IDLE;
					end
				end
				default: state_q <= pgc_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pgc_pkg::ST_IDLE: begin
				px_q     <= req.coord_x;
				pz_q     <= req.coord_z;
				res_in_q <= 1'b0;
				res_x_q  <= '0;
				res_z_q  <= '0;
				res_d_q  <= '1;
			end
			pgc_pkg::ST_PREV: begin
				ax_q <= rd_x_q;
				az_q <= rd_z_q;
			end
			pgc_pkg::ST_LOAD: begin
				bx_q <= rd_x_q;
				bz_q <= rd_z_q;
			end
			pgc_pkg::ST_MULT: begin
				case (step_q)
					3'd1: p1_q <= mul_q;
					3'd3: den_q <= mul_ext;
					3'd4: den_q <= den_q + mul_ext;
					3'd5: num_q <= mul_ext;
					3'd6: num_q <= num_q + mul_ext;
					default: ;
				endcase
			end
			pgc_pkg::ST_DECIDE: begin
				rx_q <= '0;
				rz_q <= '0;
				qx_q <= '0;
				qz_q <= '0;
				mx_q <= dx[DW-1] ? DW'(-dx) : dx;
				mz_q <= dz[DW-1] ? DW'(-dz) : dz;
				sx_q <= dx[DW-1];
				sz_q <= dz[DW-1];
				if ((den_q == '0) || num_q[SW-1]) begin
					cx_q <= ax_q;
					cz_q <= az_q;
				end else begin
					cx_q <= bx_q;
					cz_q <= bz_q;
				end
			end
			pgc_pkg::ST_DIV: begin
				rx_q <= stx[PW-1:0];
				rz_q <= stz[PW-1:0];
				qx_q <= {qx_q[W-1:0], 1'b0} + DW'(stx[PW+1:PW]);
				qz_q <= {qz_q[W-1:0], 1'b0} + DW'(stz[PW+1:PW]);
			end
			pgc_pkg::ST_ROUND: begin
				qx_q <= qx_q + DW'({rx_q, 1'b0} >= den_q);
				qz_q <= qz_q + DW'({rz_q, 1'b0} >= den_q);
			end
			pgc_pkg::ST_APPLY: begin
				cx_q <= cx_sum[W-1:0];
				cz_q <= cz_sum[W-1:0];
			end
			pgc_pkg::ST_DIST: begin
				if (step_q == 3'd1) begin
					d2_q <= mul_ext;
				end else if (step_q == 3'd2) begin
					d2_q <= d2_q + mul_ext;
				end
			end
			pgc_pkg::ST_CMP: begin
				best_q <= chosen;
				s_q    <= chosen[PW-1:0];
				rem_q  <= '0;
				root_q <= '0;
				ax_q   <= bx_q;
				az_q   <= bz_q;
				if (better) begin
					res_x_q <= cx_q;
					res_z_q <= cz_q;
				end
				if ((i_q == last) && odd_q) begin
					res_in_q <= 1'b1;
					res_x_q  <= px_q;
					res_z_q  <= pz_q;
					res_d_q  <= '0;
				end
			end
			pgc_pkg::ST_SQRT: begin
				s_q    <= {s_q[PW-3:0], 2'b00};
				rem_q  <= rem_next;
				root_q <= root_n;
				if (bit_q == '0) begin
					res_d_q <= root_n;
				end
			end
			pgc_pkg::ST_FIN: begin
				if (out_load) begin
					out_in_q <= res_in_q;
					out_x_q  <= res_x_q;
					out_z_q  <= res_z_q;
					out_d_q  <= res_d_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid      = out_v_q;
	assign rsp.inside_res = out_in_q;
	assign rsp.goal_x     = out_x_q;
	assign rsp.goal_z     = out_z_q;
	assign rsp.distance   = out_d_q;

	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.inside_res) |-> (rsp.distance == '0))
		else $error("inside item carries a nonzero distance");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == pgc_pkg::ST_FIN) && rsp.valid && !rsp.ready)
		|=> (state_q == pgc_pkg::ST_FIN))
		else $error("result overwrote an item still waiting at the output");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pgc_pkg::ST_DIV) |-> (({1'b0, rx_q} < den_q) && ({1'b0, rz_q} < den_q)))
		else $error("divider remainder left its range");

	a_edge_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pgc_pkg::ST_MULT) |-> (i_q <= last))
		else $error("edge index ran past the last vertex");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the polygon geofence clamp: vertex loads, queries and count settings.
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = 32;
	localparam int NV = 64;
	localparam int IW = pgc_pkg::IDX_WIDTH;
	localparam int KW = pgc_pkg::CNT_WIDTH;
	localparam longint ONE = 65536;
	localparam logic [CW:0] DIST_ALL = '1;
	localparam int SETTLE = 120;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic in_flag;
		logic signed [CW-1:0] gx;
		logic signed [CW-1:0] gz;
		logic [CW:0] gap;
	} fence_t;

	typedef enum logic [1:0] {ROW_SEND, ROW_CHECKED, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic op;
		logic [IW-1:0] idx;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] z;
		fence_t exp;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [KW-1:0] cfg_data;

	pgc_req_if #(.COORD_WIDTH(CW)) req_bus ();
	pgc_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();

	polygon_geofence_clamp_top #(.MAX_VERTICES(NV), .COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	longint vert_x [NV];
	longint vert_z [NV];
	int unsigned vert_count;
	fence_t fence_q[$];
	row_t plan[$];
	int errors;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	function automatic longint round_share(wide_t num, wide_t den, longint v);
		wide_t m;
		wide_t q;
		m = (v < 0) ? -wide_t'(v) : wide_t'(v);
		q = (2 * num * m + den) / (2 * den);
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Even-odd inside test, then the nearest clamped point over all edges.
	function automatic fence_t clamp_point(longint px, longint pz);
		fence_t r;
		int n;
		int j;
		bit odd;
		longint d, ax, az, bx, bz, dx, dz, cx, cz;
		wide_t lhs, rhs, den, num, d2, best, c;
		r.in_flag = 1'b0;
		r.gx = '0;
		r.gz = '0;
		r.gap = DIST_ALL;
		n = (vert_count > NV) ? NV : vert_count;
		if (n == 0) return r;
		odd = 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			if ((vert_z[i] < pz && vert_z[j] >= pz) || (vert_z[j] < pz && vert_z[i] >= pz)) begin
				d = vert_z[j] - vert_z[i];
				lhs = wide_t'(pz - vert_z[i]) * wide_t'(vert_x[j] - vert_x[i]);
				rhs = wide_t'(px - vert_x[i]) * wide_t'(d);
				if ((d > 0 && lhs < rhs) || (d < 0 && lhs > rhs)) odd = !odd;
			end
			j = i;
		end
		if (odd) begin
			r.in_flag = 1'b1;
			r.gx = px[CW-1:0];
			r.gz = pz[CW-1:0];
			r.gap = '0;
			return r;
		end
		best = '0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			ax = vert_x[j];
			az = vert_z[j];
			bx = vert_x[i];
			bz = vert_z[i];
			dx = bx - ax;
			dz = bz - az;
			den = wide_t'(dx) * wide_t'(dx) + wide_t'(dz) * wide_t'(dz);
			num = wide_t'(px - ax) * wide_t'(dx) + wide_t'(pz - az) * wide_t'(dz);
			if (den == 0 || num < 0) begin
				cx = ax;
				cz = az;
			end else if (num > den) begin
				cx = bx;
				cz = bz;
			end else begin
				cx = ax + round_share(num, den, dx);
				cz = az + round_share(num, den, dz);
			end
			d2 = wide_t'(px - cx) * wide_t'(px - cx) + wide_t'(pz - cz) * wide_t'(pz - cz);
			if (i == 0 || d2 < best) begin
				best = d2;
				r.gx = cx[CW-1:0];
				r.gz = cz[CW-1:0];
			end
			j = i;
		end
		c = '0;
		for (int b = CW + 1; b >= 0; b--) begin
			if ((c | (wide_t'(1) << b)) * (c | (wide_t'(1) << b)) <= best)
				c = c | (wide_t'(1) << b);
		end
		r.gap = (c > wide_t'(DIST_ALL)) ? DIST_ALL : c[CW:0];
		return r;
	endfunction

	task automatic send_item(logic op, logic [IW-1:0] idx, logic signed [CW-1:0] x,
			logic signed [CW-1:0] z, bit typed, fence_t exp);
		if (!quiet && $urandom_range(3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.operation <= op;
		req_bus.vertex_index <= idx;
		req_bus.coord_x <= x;
		req_bus.coord_z <= z;
		do @(posedge clk); while (!req_bus.ready);
		if (op == pgc_pkg::OP_WRITE) begin
			vert_x[idx] = longint'(x);
			vert_z[idx] = longint'(z);
		end else if (typed) begin
			fence_q = {fence_q, exp};
		end else begin
			fence_q = {fence_q, clamp_point(longint'(x), longint'(z))};
		end
	endtask

	task automatic drain;
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (fence_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(int unsigned n);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= n[KW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		vert_count = n;
	endtask

	task automatic add_row(row_kind_t k, logic op, int idx, longint x, longint z, fence_t e);
		row_t r;
		r.kind = k;
		r.op = op;
		r.idx = idx[IW-1:0];
		r.x = x[CW-1:0];
		r.z = z[CW-1:0];
		r.exp = e;
		plan = {plan, r};
	endtask

	always @(posedge clk) begin
		fence_t e;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (fence_q.size() == 0) begin
				$display("%0t: result item with nothing expected: %0b %0d %0d %0d", $time,
					rsp_bus.inside_res, rsp_bus.goal_x, rsp_bus.goal_z, rsp_bus.distance);
				errors++;
			end else begin
				e = fence_q.pop_front();
				if (rsp_bus.inside_res !== e.in_flag) begin
					$display("%0t: inside_res expected %0b actual %0b", $time, e.in_flag,
						rsp_bus.inside_res);
					errors++;
				end
				if (rsp_bus.goal_x !== e.gx) begin
					$display("%0t: goal_x expected %0d actual %0d", $time, e.gx, rsp_bus.goal_x);
					errors++;
				end
				if (rsp_bus.goal_z !== e.gz) begin
					$display("%0t: goal_z expected %0d actual %0d", $time, e.gz, rsp_bus.goal_z);
					errors++;
				end
				if (rsp_bus.distance !== e.gap) begin
					$display("%0t: distance expected %0d actual %0d", $time, e.gap,
						rsp_bus.distance);
					errors++;
				end
			end
		end
	end

	initial begin
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(4) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		fence_t none;
		fence_t empty_res;
		fence_t hit;
		int counts [8] = '{3, 1, 64, 127, 5, 0, 7, 4};
		int n;
		longint cx, cz, rad, x, z;
		none = '{1'b0, '0, '0, '0};
		empty_res = '{1'b0, '0, '0, DIST_ALL};
		errors = 0;
		quiet = 1'b0;
		vert_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.operation = pgc_pkg::OP_WRITE;
		req_bus.vertex_index = '0;
		req_bus.coord_x = '0;
		req_bus.coord_z = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty polygon gives the origin and a saturated distance.
		add_row(ROW_CHECKED, pgc_pkg::OP_QUERY, 0, 0, 0, empty_res);
		add_row(ROW_CHECKED, pgc_pkg::OP_QUERY, 63, 2147483647, -2147483648, empty_res);
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 0, -10 * ONE, -10 * ONE, none);
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 1, 10 * ONE, -10 * ONE, none);
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 2, 10 * ONE, 10 * ONE, none);
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 3, -10 * ONE, 10 * ONE, none);
		add_row(ROW_COUNT, pgc_pkg::OP_WRITE, 4, 0, 0, none);
		hit = '{1'b1, '0, '0, '0};
		add_row(ROW_CHECKED, pgc_pkg::OP_QUERY, 0, 0, 0, hit);
		hit = '{1'b1, 32'(ONE), 32'(2 * ONE), '0};
		add_row(ROW_CHECKED, pgc_pkg::OP_QUERY, 0, ONE, 2 * ONE, hit);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, 20 * ONE, 0, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, 2147483647, 2147483647, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, -2147483648, -2147483648, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, -2147483648, 2147483647, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, 10 * ONE, 10 * ONE, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, 3 * ONE, -10 * ONE, none);
		// A repeated vertex makes an edge of zero length.
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 4, -10 * ONE, 10 * ONE, none);
		add_row(ROW_COUNT, pgc_pkg::OP_WRITE, 5, 0, 0, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, -20 * ONE, 20 * ONE, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, -10 * ONE, 30 * ONE, none);
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 5, -2147483648, -2147483648, none);
		add_row(ROW_SEND, pgc_pkg::OP_WRITE, 6, 2147483647, 2147483647, none);
		add_row(ROW_COUNT, pgc_pkg::OP_WRITE, 7, 0, 0, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, 2147483647, -2147483648, none);
		add_row(ROW_SEND, pgc_pkg::OP_QUERY, 0, 5 * ONE, 0, none);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_COUNT)
				set_count(plan[k].idx);
			else
				send_item(plan[k].op, plan[k].idx, plan[k].x, plan[k].z,
					plan[k].kind == ROW_CHECKED, plan[k].exp);
		end

		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph >= 6);
			n = counts[ph];
			cx = longint'($signed($urandom_range(0, 32'h3fff_ffff))) - 64'h2000_0000;
			cz = longint'($signed($urandom_range(0, 32'h3fff_ffff))) - 64'h2000_0000;
			rad = longint'($urandom_range(1, 1 << 22));
			if (n <= NV) begin
				for (int v = 0; v < n; v++) begin
					if ($urandom_range(5) == 0) begin
						x = longint'($signed(32'($urandom())));
						z = longint'($signed(32'($urandom())));
					end else begin
						x = cx + longint'($urandom_range(0, 2 * rad)) - rad;
						z = cz + longint'($urandom_range(0, 2 * rad)) - rad;
					end
					send_item(pgc_pkg::OP_WRITE, v[IW-1:0], x[CW-1:0], z[CW-1:0], 1'b0, none);
				end
			end
			set_count(n);
			for (int q = 0; q < ((n >= NV) ? 3 : 5); q++) begin
				if ($urandom_range(9) == 0) begin
					x = cx + longint'($urandom_range(0, 2 * rad)) - rad;
					z = cz + longint'($urandom_range(0, 2 * rad)) - rad;
					send_item(pgc_pkg::OP_WRITE, IW'($urandom_range(0, NV - 1)), x[CW-1:0],
						z[CW-1:0], 1'b0, none);
				end
				if ($urandom_range(4) == 0) begin
					x = longint'($signed(32'($urandom())));
					z = longint'($signed(32'($urandom())));
				end else begin
					x = cx + longint'($urandom_range(0, 4 * rad)) - 2 * rad;
					z = cz + longint'($urandom_range(0, 4 * rad)) - 2 * rad;
				end
				send_item(pgc_pkg::OP_QUERY, IW'($urandom_range(0, NV - 1)), x[CW-1:0],
					z[CW-1:0], 1'b0, none);
			end
		end

		drain();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/pgc_pkg.sv
src/pgc_if.sv
src/polygon_geofence_clamp_top.sv
bench/tb_top.sv
